// File: hw/rtl/ifmt_pkg.sv
// ifmt_pkg: types, widths and character codes for the integer decimal field formatter
// no dependencies; imported by every rtl file of the block
`default_nettype none

package ifmt_pkg;

   localparam int VALUE_W = 64;
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = 20;
   localparam int BCD_W   = DIGITS * DIGIT_W;
   localparam int ND_W    = 5;
   localparam int SHIFT_W = 6;
   localparam int CHAR_W  = 8;
   localparam int WIDTH_W = 7;
   localparam int PREC_W  = 6;
   localparam int POS_W   = 7;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic               neg;
      logic               plus;
      logic               space;
      logic               left;
      logic [WIDTH_W-1:0] width;
      logic [PREC_W-1:0]  prec;
   } fmt_type;

   typedef struct packed {
      logic             valid;
      logic [BCD_W-1:0] digits;
      logic [ND_W-1:0]  nd;
      fmt_type          fmt;
   } conv_type;

   typedef enum logic [1:0] {
      BCD_IDLE,
      BCD_SHIFT,
      BCD_NORM,
      BCD_DONE
   } bcd_state_type;

   typedef enum logic [1:0] {
      EM_IDLE,
      EM_SIZE,
      EM_PLACE,
      EM_RUN
   } emit_state_type;

endpackage

`default_nettype wire

// File: hw/rtl/ifmt_channels.sv
// ifmt_req_if / ifmt_rsp_if: valid-ready channels for formatter requests and characters
// depends on ifmt_pkg for field widths
`default_nettype none

interface ifmt_req_if;
   import ifmt_pkg::*;
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic                mode;
   logic                plus_flag;
   logic                space_flag;
   logic                left_flag;
   logic [WIDTH_W-1:0]  field_width;
   logic [PREC_W-1:0]   min_digits;

   modport source (
      output valid, value, mode, plus_flag, space_flag, left_flag, field_width, min_digits,
      input  ready
   );
   modport sink (
      input  valid, value, mode, plus_flag, space_flag, left_flag, field_width, min_digits,
      output ready
   );
endinterface

interface ifmt_rsp_if;
   import ifmt_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last;

   modport source (output valid, char_out, last, input ready);
   modport sink   (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ifmt_bcd.sv
// ifmt_bcd: bit-serial binary to bcd converter (shift-and-add-3) with leading zero strip
// depends on ifmt_pkg
`default_nettype none

module ifmt_bcd
   import ifmt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [VALUE_W-1:0] in_mag,
   input  wire fmt_type            in_fmt,
   output logic                    ready,
   output conv_type                conv,
   input  wire logic               take
);

   bcd_state_type      state_ff, state_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   adj;
   logic [SHIFT_W-1:0] cnt_ff, cnt_in;
   logic [ND_W-1:0]    nd_ff, nd_in;
   fmt_type            fmt_ff, fmt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BCD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      nd_ff  <= nd_in;
      fmt_ff <= fmt_in;
   end

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         if (bcd_ff[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
            adj[k*DIGIT_W +: DIGIT_W] = bcd_ff[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         end else begin
            adj[k*DIGIT_W +: DIGIT_W] = bcd_ff[k*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      nd_in    = nd_ff;
      fmt_in   = fmt_ff;
      unique case (state_ff)
         BCD_IDLE: begin
            if (start) begin
               mag_in   = in_mag;
               fmt_in   = in_fmt;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = BCD_SHIFT;
            end
         end
         BCD_SHIFT: begin
            bcd_in = {adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
            mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + SHIFT_W'(1);
            if (&cnt_ff) begin
               nd_in    = ND_W'(DIGITS);
               state_in = BCD_NORM;
            end
         end
         BCD_NORM: begin
            // drop leading zero digits, keep at least one
            if (bcd_ff[BCD_W-1 -: DIGIT_W] == '0 && nd_ff != ND_W'(1)) begin
               bcd_in = {bcd_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               nd_in  = nd_ff - ND_W'(1);
            end else begin
               state_in = BCD_DONE;
            end
         end
         BCD_DONE: begin
            if (take) begin
               state_in = BCD_IDLE;
            end
         end
         default: state_in = BCD_IDLE;
      endcase
   end

   assign ready       = (state_ff == BCD_IDLE);
   assign conv.valid  = (state_ff == BCD_DONE);
   assign conv.digits = bcd_ff;
   assign conv.nd     = nd_ff;
   assign conv.fmt    = fmt_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ifmt_emit.sv
// ifmt_emit: lays out sign, zero fill, digits and space padding, one character per cycle while the receiver is ready
// depends on ifmt_pkg and ifmt_rsp_if; takes normalized digits from ifmt_bcd
`default_nettype none

module ifmt_emit
   import ifmt_pkg::*;
#(
   parameter int MAX_FIELD = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire conv_type conv,
   output logic       take,
   ifmt_rsp_if.source rsp
);

   localparam int CNT_BITS = ($clog2(MAX_FIELD + 1) > POS_W + 1) ?
                             $clog2(MAX_FIELD + 1) : POS_W + 1;

   emit_state_type      state_ff, state_in;
   logic [BCD_W-1:0]    digits_ff, digits_in;
   logic [ND_W-1:0]     nd_ff, nd_in;
   fmt_type             fmt_ff, fmt_in;
   logic                sgn_ff, sgn_in;
   logic [PREC_W-1:0]   zeros_ff, zeros_in;
   logic [POS_W-1:0]    core_ff, core_in;
   logic [POS_W-1:0]    e_lead_ff, e_lead_in;
   logic [POS_W-1:0]    e_sign_ff, e_sign_in;
   logic [POS_W-1:0]    e_zero_ff, e_zero_in;
   logic [POS_W-1:0]    e_core_ff, e_core_in;
   logic [CNT_BITS-1:0] emit_ff, emit_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic                last_ff, last_in;
   logic [POS_W-1:0]    total;
   logic [POS_W-1:0]    lead;
   logic [CHAR_W-1:0]   sign_char;
   logic                slot_free;
   logic                is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EM_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      nd_ff     <= nd_in;
      fmt_ff    <= fmt_in;
      sgn_ff    <= sgn_in;
      zeros_ff  <= zeros_in;
      core_ff   <= core_in;
      e_lead_ff <= e_lead_in;
      e_sign_ff <= e_sign_in;
      e_zero_ff <= e_zero_in;
      e_core_ff <= e_core_in;
      emit_ff   <= emit_in;
      idx_ff    <= idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   always_comb begin
      priority if (fmt_ff.plus && !fmt_ff.neg) begin
         sign_char = CHAR_PLUS;
      end else if (fmt_ff.space && !fmt_ff.neg) begin
         sign_char = CHAR_SPACE;
      end else begin
         sign_char = CHAR_MINUS;
      end
   end

   assign total     = (POS_W'(fmt_ff.width) > core_ff) ? POS_W'(fmt_ff.width) : core_ff;
   assign lead      = fmt_ff.left ? '0 : (total - core_ff);
   assign slot_free = !valid_ff || rsp.ready;
   assign is_last   = ((idx_ff + CNT_BITS'(1)) == emit_ff);
   assign take      = (state_ff == EM_IDLE) && conv.valid;

   always_comb begin
      state_in  = state_ff;
      digits_in = digits_ff;
      nd_in     = nd_ff;
      fmt_in    = fmt_ff;
      sgn_in    = sgn_ff;
      zeros_in  = zeros_ff;
      core_in   = core_ff;
      e_lead_in = e_lead_ff;
      e_sign_in = e_sign_ff;
      e_zero_in = e_zero_ff;
      e_core_in = e_core_ff;
      emit_in   = emit_ff;
      idx_in    = idx_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      valid_in  = valid_ff && !rsp.ready;
      unique case (state_ff)
         EM_IDLE: begin
            if (conv.valid) begin
               digits_in = conv.digits;
               nd_in     = conv.nd;
               fmt_in    = conv.fmt;
               state_in  = EM_SIZE;
            end
         end
         EM_SIZE: begin
            sgn_in = fmt_ff.plus || fmt_ff.space || fmt_ff.neg;
            if (fmt_ff.prec > PREC_W'(nd_ff)) begin
               zeros_in = fmt_ff.prec - PREC_W'(nd_ff);
            end else begin
               zeros_in = '0;
            end
            core_in  = POS_W'(sgn_in) + POS_W'(nd_ff) + POS_W'(zeros_in);
            state_in = EM_PLACE;
         end
         EM_PLACE: begin
            // field boundaries: lead pad, sign, zero fill, digits, trailing pad
            e_lead_in = lead;
            e_sign_in = lead + POS_W'(sgn_ff);
            e_zero_in = lead + POS_W'(sgn_ff) + POS_W'(zeros_ff);
            e_core_in = lead + core_ff;
            if (CNT_BITS'(total) > CNT_BITS'(MAX_FIELD)) begin
               emit_in = CNT_BITS'(MAX_FIELD);
            end else begin
               emit_in = CNT_BITS'(total);
            end
            idx_in   = '0;
            state_in = EM_RUN;
         end
         EM_RUN: begin
            if (slot_free) begin
               valid_in = 1'b1;
               last_in  = is_last;
               idx_in   = idx_ff + CNT_BITS'(1);
               priority if (idx_ff < CNT_BITS'(e_lead_ff)) begin
                  char_in = CHAR_SPACE;
               end else if (idx_ff < CNT_BITS'(e_sign_ff)) begin
                  char_in = sign_char;
               end else if (idx_ff < CNT_BITS'(e_zero_ff)) begin
                  char_in = CHAR_ZERO;
               end else if (idx_ff < CNT_BITS'(e_core_ff)) begin
                  char_in   = CHAR_ZERO + CHAR_W'(digits_ff[BCD_W-1 -: DIGIT_W]);
                  digits_in = {digits_ff[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
               end else begin
                  char_in = CHAR_SPACE;
               end
               if (is_last) begin
                  state_in = EM_IDLE;
               end
            end
         end
         default: state_in = EM_IDLE;
      endcase
   end

   assign rsp.valid    = valid_ff;
   assign rsp.char_out = char_ff;
   assign rsp.last     = last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/integer_decimal_field_formatter_top.sv
// path: a request is shifted and then normalized in ifmt_bcd, handed off to ifmt_emit,
// sized and placed there, and its first character is registered in the run state
// throughput: one character per cycle within a field while the receiver is ready; the next conversion
// runs while the field drains, so a request can be taken before the last field is sent
// reset: synchronous, active high; clears both sequencers and the output valid
`default_nettype none

module integer_decimal_field_formatter_top
   import ifmt_pkg::*;
#(
   parameter int MAX_FIELD = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ifmt_req_if.sink   req_if,
   ifmt_rsp_if.source rsp_if
);

   logic               start;
   logic               neg;
   logic [VALUE_W-1:0] mag;
   fmt_type            fmt;
   conv_type           conv;
   logic               take;
   logic               bcd_ready;

   assign req_if.ready = bcd_ready;
   assign start        = req_if.valid && bcd_ready;

   // signed mode with the top bit set is negative; unsigned mode never is
   assign neg = !req_if.mode && req_if.value[VALUE_W-1];
   assign mag = neg ? (~req_if.value + VALUE_W'(1)) : req_if.value;

   assign fmt.neg   = neg;
   assign fmt.plus  = req_if.plus_flag;
   assign fmt.space = req_if.space_flag;
   assign fmt.left  = req_if.left_flag;
   assign fmt.width = req_if.field_width;
   assign fmt.prec  = req_if.min_digits;

   ifmt_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .in_mag (mag),
      .in_fmt (fmt),
      .ready  (bcd_ready),
      .conv   (conv),
      .take   (take)
   );

   ifmt_emit #(
      .MAX_FIELD (MAX_FIELD)
   ) u_emit (
      .clock (clock),
      .reset (reset),
      .conv  (conv),
      .take  (take),
      .rsp   (rsp_if)
   );

endmodule

`default_nettype wire

// File: hw/rtl/ifmt_checker.sv
// ifmt_checker: port-level assertions for the formatter, attached to the top level by bind
// depends on ifmt_pkg and integer_decimal_field_formatter_top
`default_nettype none

module ifmt_checker
   import ifmt_pkg::*;
#(
   parameter int MAX_FIELD = 64
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [CHAR_W-1:0] char_out,
   input wire logic              last
);

   localparam int CB = $clog2(MAX_FIELD + 1);

   logic [CB-1:0] cnt_ff, cnt_in;
   logic          rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // characters transferred so far in the current field
   always_comb begin
      cnt_in = cnt_ff;
      if (rsp_xfer) begin
         cnt_in = last ? '0 : (cnt_ff + CB'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(char_out) && $stable(last)))
      else $error("stalled character changed");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (char_out == CHAR_SPACE || char_out == CHAR_PLUS ||
                     char_out == CHAR_MINUS ||
                     (char_out >= CHAR_ZERO && char_out <= CHAR_NINE)))
      else $error("character outside the decimal field set");

   a_field_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && cnt_ff == CB'(MAX_FIELD - 1)) |-> last)
      else $error("field longer than the maximum without last");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && (req_ready || !req_valid || req_ready)))
      else $error("output valid after reset");

endmodule

bind integer_decimal_field_formatter_top ifmt_checker #(
   .MAX_FIELD (MAX_FIELD)
) u_ifmt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .char_out  (rsp_if.char_out),
   .last      (rsp_if.last)
);

`default_nettype wire
